// ----- hw/rtl/hkrd_pkg.sv -----
package hkrd_pkg;

  localparam int unsigned KeyW = 8;
  localparam int unsigned ModEvents = 3;

  localparam logic KIND_PRESS   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic [KeyW-1:0] CODE_CTRL  = 8'd224;
  localparam logic [KeyW-1:0] CODE_SHIFT = 8'd225;
  localparam logic [KeyW-1:0] CODE_ALT   = 8'd226;

  localparam logic [KeyW-1:0] MASK_CTRL  = 8'h11;
  localparam logic [KeyW-1:0] MASK_SHIFT = 8'h22;
  localparam logic [KeyW-1:0] MASK_ALT   = 8'h44;

  localparam logic [1:0] MSEL_CTRL  = 2'd0;
  localparam logic [1:0] MSEL_SHIFT = 2'd1;
  localparam logic [1:0] MSEL_ALT   = 2'd2;

  typedef logic [KeyW-1:0] key_t;

  function automatic key_t merged_mask(input logic [1:0] sel);
    key_t m;
    case (sel)
      MSEL_CTRL:  m = MASK_CTRL;
      MSEL_SHIFT: m = MASK_SHIFT;
      MSEL_ALT:   m = MASK_ALT;
      default:    m = '0;
    endcase
    return m;
  endfunction

  function automatic key_t mod_code(input logic [1:0] sel);
    key_t c;
    case (sel)
      MSEL_CTRL:  c = CODE_CTRL;
      MSEL_SHIFT: c = CODE_SHIFT;
      MSEL_ALT:   c = CODE_ALT;
      default:    c = '0;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/hkrd_match.sv -----
module hkrd_match #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  logic [KEY_SLOTS-1:0][hkrd_pkg::KeyW-1:0] slots_i,
  input  hkrd_pkg::key_t                           probe_i,
  output logic                                     found_o
);

  logic [KEY_SLOTS-1:0] eq;

  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      eq[i] = (slots_i[i] == probe_i);
    end
  end

  assign found_o = |eq;

endmodule

// ----- hw/rtl/hid_keyboard_report_diff.sv -----
// Turns boot keyboard reports into key press and release events. A report is
// compared with the one before it by a single compare unit that checks one
// slot against all stored slots per cycle while the scan is not stalled: first
// the new slots (presses), then the old slots (releases), then Ctrl, Shift and
// Alt with left and right merged (codes 224, 225, 226). Events leave one at a
// time, the final one of a report flagged by tlast; a report that changes
// nothing gives no event. A new report is taken only once the last one is
// through; the scan stalls while the output register is held by the downstream
// side and a further event is waiting.
module hid_keyboard_report_diff #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // modifier_bits, slot_0 .. slot_(KEY_SLOTS-1)
  input  logic [8*(KEY_SLOTS+1)-1:0]      s_axis_tdata_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // key_code
  output logic [7:0]                      m_axis_tdata_o,
  // event_kind
  output logic                            m_axis_tuser_o,
  // last_event
  output logic                            m_axis_tlast_o,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i
);

  localparam int unsigned SW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int unsigned CW = (SW > 2) ? SW : 2;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DOWN  = 3'd1;
  localparam logic [2:0] ST_UP    = 3'd2;
  localparam logic [2:0] ST_MOD   = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  logic [2:0] st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [KEY_SLOTS-1:0][hkrd_pkg::KeyW-1:0] cur_q, prev_q, table_sel;
  hkrd_pkg::key_t mods_q, prev_mods_q;

  logic pend_valid_q, pend_valid_d;
  logic pend_kind_q;
  hkrd_pkg::key_t pend_code_q;

  logic out_valid_q, out_valid_d;
  logic out_kind_q, out_last_q;
  hkrd_pkg::key_t out_code_q;

  logic s_acc, running, phase_end, out_free, stall, advance;
  logic push, push_last, store, found, on_now, on_before;
  logic ev_hit, ev_kind;
  logic [SW-1:0] sidx;
  hkrd_pkg::key_t probe, ev_code;

  assign s_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign running = (st_q == ST_DOWN) || (st_q == ST_UP) || (st_q == ST_MOD);
  assign sidx    = cnt_q[SW-1:0];

  assign probe     = (st_q == ST_UP) ? prev_q[sidx] : cur_q[sidx];
  assign table_sel = (st_q == ST_UP) ? cur_q : prev_q;

  hkrd_match #(
    .KEY_SLOTS(KEY_SLOTS)
  ) u_match (
    .slots_i(table_sel),
    .probe_i(probe),
    .found_o(found)
  );

  assign on_now    = |(mods_q & hkrd_pkg::merged_mask(cnt_q[1:0]));
  assign on_before = |(prev_mods_q & hkrd_pkg::merged_mask(cnt_q[1:0]));

  always_comb begin
    ev_hit  = 1'b0;
    ev_kind = hkrd_pkg::KIND_PRESS;
    ev_code = probe;
    case (st_q)
      ST_DOWN: begin
        ev_hit = (probe != '0) && !found;
      end
      ST_UP: begin
        ev_hit  = (probe != '0) && !found;
        ev_kind = hkrd_pkg::KIND_RELEASE;
      end
      ST_MOD: begin
        ev_hit  = (on_now != on_before);
        ev_kind = on_now ? hkrd_pkg::KIND_PRESS : hkrd_pkg::KIND_RELEASE;
        ev_code = hkrd_pkg::mod_code(cnt_q[1:0]);
      end
      default: begin
        ev_hit = 1'b0;
      end
    endcase
  end

  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign phase_end = (st_q == ST_MOD) ? (cnt_q == CW'(hkrd_pkg::ModEvents - 1))
                                      : (cnt_q == CW'(KEY_SLOTS - 1));
  assign stall     = running && ev_hit && pend_valid_q && !out_free;
  assign advance   = running && !stall;

  always_comb begin
    st_d         = st_q;
    cnt_d        = cnt_q;
    pend_valid_d = pend_valid_q;
    push         = 1'b0;
    push_last    = 1'b0;
    store        = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (s_acc) begin
          st_d  = ST_DOWN;
          cnt_d = '0;
        end
      end
      ST_DOWN, ST_UP, ST_MOD: begin
        if (advance) begin
          if (ev_hit) begin
            push         = pend_valid_q;
            pend_valid_d = 1'b1;
          end
          if (phase_end) begin
            cnt_d = '0;
            st_d  = (st_q == ST_DOWN) ? ST_UP : (st_q == ST_UP) ? ST_MOD : ST_FLUSH;
          end else begin
            cnt_d = cnt_q + CW'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_q || out_free) begin
          push         = pend_valid_q;
          push_last    = 1'b1;
          pend_valid_d = 1'b0;
          store        = 1'b1;
          st_d         = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (push) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= ST_IDLE;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      prev_q       <= '0;
      prev_mods_q  <= '0;
    end else begin
      st_q         <= st_d;
      cnt_q        <= cnt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (store) begin
        prev_q      <= cur_q;
        prev_mods_q <= mods_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      mods_q <= s_axis_tdata_i[7:0];
      cur_q  <= s_axis_tdata_i[8*(KEY_SLOTS+1)-1:8];
    end
    if (push) begin
      out_kind_q <= pend_kind_q;
      out_code_q <= pend_code_q;
      out_last_q <= push_last;
    end
    if (advance && ev_hit) begin
      pend_kind_q <= ev_kind;
      pend_code_q <= ev_code;
    end
  end

  assign s_axis_tready_o = (st_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_code_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ----- hw/rtl/hkrd_checker.sv -----
module hkrd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_i,
  input logic [7:0] m_axis_tdata_i,
  input logic       m_axis_tuser_i,
  input logic       m_axis_tlast_i,
  input logic       m_axis_tvalid_i,
  input logic       m_axis_tready_i
);

  // busy once a report is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_i) |=> !s_axis_tready_i)
    else $error("ready after accepted request");

  // final event only appears once the report is fully processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_i && m_axis_tlast_i) |-> s_axis_tready_i)
    else $error("last event while still busy");

  // held event stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_i && !m_axis_tready_i) |=>
      (m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i)
       && $stable(m_axis_tlast_i)))
    else $error("stalled event changed");

endmodule

bind hid_keyboard_report_diff hkrd_checker u_hkrd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_i(s_axis_tready_o),
  .m_axis_tdata_i (m_axis_tdata_o),
  .m_axis_tuser_i (m_axis_tuser_o),
  .m_axis_tlast_i (m_axis_tlast_o),
  .m_axis_tvalid_i(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i)
);

// ----- tb/hkrd_checker.sv -----
module hkrd_scoreboard #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // modifier_bits, slot_0 .. slot_(KEY_SLOTS-1)
  input  logic [8*(KEY_SLOTS+1)-1:0] s_axis_tdata_i,
  input  logic                       s_axis_tvalid_i,
  input  logic                       s_axis_tready_i,
  // key_code
  input  logic [7:0]                 m_axis_tdata_i,
  // event_kind
  input  logic                       m_axis_tuser_i,
  // last_event
  input  logic                       m_axis_tlast_i,
  input  logic                       m_axis_tvalid_i,
  input  logic                       m_axis_tready_i,
  output int unsigned                errors_o,
  output int unsigned                pending_o,
  output int unsigned                checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ReportW = 8 * (KEY_SLOTS + 1);

  typedef struct packed {
    logic           kind;
    hkrd_pkg::key_t code;
    logic           last;
  } exp_event_t;

  exp_event_t     expected_events [$];
  exp_event_t     want;
  hkrd_pkg::key_t held_slots [KEY_SLOTS];
  hkrd_pkg::key_t held_mods;

  function automatic bit holds_key(input hkrd_pkg::key_t slots [KEY_SLOTS],
                                   input hkrd_pkg::key_t code);
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (slots[i] == code) return 1'b1;
    end
    return 1'b0;
  endfunction

  // works out the events of one report and takes it as the new held state
  task automatic predict_events(input logic [ReportW-1:0] report);
    hkrd_pkg::key_t new_slots [KEY_SLOTS];
    hkrd_pkg::key_t new_mods;
    hkrd_pkg::key_t mod_masks [3];
    hkrd_pkg::key_t mod_codes [3];
    exp_event_t     found [$];
    logic           now_on;
    logic           was_on;
    mod_masks = '{hkrd_pkg::MASK_CTRL, hkrd_pkg::MASK_SHIFT, hkrd_pkg::MASK_ALT};
    mod_codes = '{hkrd_pkg::CODE_CTRL, hkrd_pkg::CODE_SHIFT, hkrd_pkg::CODE_ALT};
    new_mods = report[7:0];
    for (int i = 0; i < KEY_SLOTS; i++) new_slots[i] = report[8*(i+1) +: 8];
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (new_slots[i] != '0 && !holds_key(held_slots, new_slots[i])) begin
        found.push_back('{hkrd_pkg::KIND_PRESS, new_slots[i], 1'b0});
      end
    end
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (held_slots[i] != '0 && !holds_key(new_slots, held_slots[i])) begin
        found.push_back('{hkrd_pkg::KIND_RELEASE, held_slots[i], 1'b0});
      end
    end
    // left and right merged
    for (int m = 0; m < 3; m++) begin
      now_on = (new_mods & mod_masks[m]) != '0;
      was_on = (held_mods & mod_masks[m]) != '0;
      if (now_on && !was_on) begin
        found.push_back('{hkrd_pkg::KIND_PRESS, mod_codes[m], 1'b0});
      end else if (!now_on && was_on) begin
        found.push_back('{hkrd_pkg::KIND_RELEASE, mod_codes[m], 1'b0});
      end
    end
    if (found.size() > 0) found[found.size()-1].last = 1'b1;
    foreach (found[i]) expected_events.push_back(found[i]);
    held_slots = new_slots;
    held_mods  = new_mods;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (held_slots[i]) held_slots[i] = '0;
      held_mods = '0;
      expected_events.delete();
      errors_o  = 0;
      pending_o = 0;
      checked_o = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) predict_events(s_axis_tdata_i);
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_events.size() == 0) begin
          $error("key_code %0d (event_kind %0d) with no event expected",
                 m_axis_tdata_i, m_axis_tuser_i);
          errors_o++;
        end else begin
          want = expected_events.pop_front();
          checked_o++;
          if (m_axis_tuser_i !== want.kind) begin
            $error("event_kind: expected %0d, got %0d", want.kind, m_axis_tuser_i);
            errors_o++;
          end
          if (m_axis_tdata_i !== want.code) begin
            $error("key_code: expected %0d, got %0d", want.code, m_axis_tdata_i);
            errors_o++;
          end
          if (m_axis_tlast_i !== want.last) begin
            $error("last_event: expected %0d, got %0d", want.last, m_axis_tlast_i);
            errors_o++;
          end
        end
      end
      pending_o = expected_events.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned KEY_SLOTS      = 6;
  localparam int unsigned ReportW        = 8 * (KEY_SLOTS + 1);
  localparam int unsigned RandomReports  = 480;
  localparam int unsigned TimeoutCycles  = 2_000_000;

  logic               clk_i;
  logic               rst_ni;
  logic [ReportW-1:0] s_axis_tdata_i;
  logic               s_axis_tvalid_i;
  logic               s_axis_tready_o;
  logic [7:0]         m_axis_tdata_o;
  logic               m_axis_tuser_o;
  logic               m_axis_tlast_o;
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b1;

  int unsigned errors;
  int unsigned pending;
  int unsigned checked;
  int unsigned cycles = 0;
  int unsigned reports_sent;
  int unsigned directed_sent;
  int unsigned hold_left = 0;
  bit          quiet_source;
  bit          steady_sink;

  hkrd_pkg::key_t cur_mods;
  hkrd_pkg::key_t cur_slots [KEY_SLOTS];

  hid_keyboard_report_diff #(
    .KEY_SLOTS(KEY_SLOTS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i)
  );

  hkrd_scoreboard #(
    .KEY_SLOTS(KEY_SLOTS)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_i(s_axis_tready_o),
    .m_axis_tdata_i (m_axis_tdata_o),
    .m_axis_tuser_i (m_axis_tuser_o),
    .m_axis_tlast_i (m_axis_tlast_o),
    .m_axis_tvalid_i(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .errors_o       (errors),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 2);
    if (roll < 95) return $urandom_range(3, 6);
    return $urandom_range(20, 60);
  endfunction

  // downstream stalls
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
      if (!steady_sink && $urandom_range(0, 3) == 0) hold_left = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > TimeoutCycles) begin
      $display("timeout after %0d cycles, %0d events outstanding", cycles, pending);
      $display("Some tests failed");
      $finish;
    end
  end

  // entered and left at a falling edge
  task automatic send_current();
    logic [ReportW-1:0] report;
    int unsigned        gap;
    report[7:0] = cur_mods;
    for (int i = 0; i < KEY_SLOTS; i++) report[8*(i+1) +: 8] = cur_slots[i];
    gap = 0;
    if (!quiet_source && $urandom_range(0, 1) == 0) gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata_i  <= report;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
    reports_sent++;
  endtask

  task automatic send_keys(input hkrd_pkg::key_t mods, input hkrd_pkg::key_t k0,
                           input hkrd_pkg::key_t k1, input hkrd_pkg::key_t k2,
                           input hkrd_pkg::key_t k3, input hkrd_pkg::key_t k4,
                           input hkrd_pkg::key_t k5);
    cur_mods  = mods;
    cur_slots = '{k0, k1, k2, k3, k4, k5};
    send_current();
  endtask

  task automatic drain_events();
    s_axis_tvalid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  // mostly small typing steps from the last report, some noise and reshuffles
  task automatic mutate_report();
    int unsigned    pick;
    int unsigned    slot;
    int unsigned    bit_sel;
    hkrd_pkg::key_t first;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      repeat ($urandom_range(1, 3)) begin
        slot = $urandom_range(0, KEY_SLOTS - 1);
        if ($urandom_range(0, 1) == 0) begin
          cur_slots[slot] = '0;
        end else if ($urandom_range(0, 4) != 0) begin
          cur_slots[slot] = hkrd_pkg::key_t'($urandom_range(4, 40));
        end else begin
          cur_slots[slot] = hkrd_pkg::key_t'($urandom_range(1, 255));
        end
      end
      if ($urandom_range(0, 2) == 0) begin
        bit_sel = $urandom_range(0, 7);
        cur_mods[bit_sel] = ~cur_mods[bit_sel];
      end
    end else if (pick < 78) begin
      if ($urandom_range(0, 1) == 0) cur_mods = cur_mods ^ (8'h88 & hkrd_pkg::key_t'($urandom));
    end else if (pick < 93) begin
      cur_mods = hkrd_pkg::key_t'($urandom);
      foreach (cur_slots[i]) begin
        cur_slots[i] = ($urandom_range(0, 3) == 0) ? hkrd_pkg::key_t'(0)
                                                   : hkrd_pkg::key_t'($urandom);
      end
    end else begin
      first = cur_slots[0];
      for (int i = 0; i < KEY_SLOTS - 1; i++) cur_slots[i] = cur_slots[i+1];
      cur_slots[KEY_SLOTS-1] = first;
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tvalid_i = 1'b0;
    reports_sent    = 0;
    quiet_source    = 1'b0;
    steady_sink     = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_keys(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);  // nothing changes
    send_keys(8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_keys(8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_keys(8'h00, 8'h00, 8'h00, 8'h00, 8'h04, 8'h00, 8'h00);  // key moved to another slot
    send_keys(8'h77, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'h55, 8'hAA);
    send_keys(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_keys(8'h88, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);  // unused modifier bits
    send_keys(8'h11, 8'h10, 8'h10, 8'h00, 8'h10, 8'h00, 8'h00);  // duplicate presses
    send_keys(8'h10, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);  // left to right ctrl
    send_keys(8'h21, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_keys(8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06);
    send_keys(8'h77, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16);  // every event at once
    send_keys(8'h07, 8'h16, 8'h15, 8'h14, 8'h13, 8'h12, 8'h11);
    send_keys(8'h70, 8'h20, 8'h20, 8'h20, 8'h00, 8'h00, 8'h00);
    send_keys(8'h70, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);  // duplicate releases
    send_keys(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_keys(8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_keys(8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    directed_sent = reports_sent;
    drain_events();

    for (int unsigned n = 0; n < RandomReports; n++) begin
      if (n % 60 == 0) begin
        quiet_source = ($urandom_range(0, 3) == 0);
        steady_sink  = ($urandom_range(0, 3) == 0);
      end
      if (n == RandomReports / 2) drain_events();
      mutate_report();
      send_current();
    end
    s_axis_tvalid_i <= 1'b0;
    steady_sink = 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (2 * KEY_SLOTS + 8) @(posedge clk_i);

    $display("%0d reports (%0d directed) gave %0d checked key events in %0d cycles",
             reports_sent, directed_sent, checked, cycles);
    $display("with random gaps on the request side and stalls on the event side");
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/hkrd_pkg.sv
hw/rtl/hkrd_match.sv
hw/rtl/hid_keyboard_report_diff.sv
hw/rtl/hkrd_checker.sv
tb/hkrd_checker.sv
tb/testbench.sv
